>>> hdl/cmgp_pkg.sv
// Shared types, constants and the gamma table for the MIDI CC to PWM duty block.
`timescale 1ns / 1ps
`default_nettype none
package cmgp_pkg;

	localparam int GAMMA_ENTRIES = 128;
	localparam int GAMMA_IDX_W   = $clog2(GAMMA_ENTRIES);

	localparam logic [7:0] CONTROL_CHANGE = 8'hB0;

	// register indexes on the configuration port
	localparam logic [2:0] REG_CC_FIRST  = 3'd0;
	localparam logic [2:0] REG_CC_SECOND = 3'd1;
	localparam logic [2:0] REG_CC_THIRD  = 3'd2;
	localparam logic [2:0] REG_MIDI_CH   = 3'd3;
	localparam logic [2:0] REG_ACT_TICKS = 3'd4;

	localparam logic [6:0] CC_FIRST_RST  = 7'd71;
	localparam logic [6:0] CC_SECOND_RST = 7'd73;
	localparam logic [6:0] CC_THIRD_RST  = 7'd72;
	localparam logic [3:0] MIDI_CH_RST   = 4'd0;
	localparam logic [7:0] ACT_TICKS_RST = 8'd10;

	// item kinds on tuser
	localparam logic KIND_BYTE = 1'b0;
	localparam logic KIND_TICK = 1'b1;

	typedef struct packed {
		logic [6:0] cc_first_channel;
		logic [6:0] cc_second_channel;
		logic [6:0] cc_third_channel;
		logic [3:0] midi_channel;
		logic [7:0] activity_ticks;
	} cfg_t;

	localparam logic [7:0] GAMMA_ROM [GAMMA_ENTRIES] = '{
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,
		8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd0,   8'd1,   8'd1,
		8'd1,   8'd1,   8'd1,   8'd1,   8'd2,   8'd2,   8'd2,   8'd2,
		8'd3,   8'd3,   8'd3,   8'd3,   8'd4,   8'd4,   8'd5,   8'd5,
		8'd6,   8'd6,   8'd7,   8'd7,   8'd8,   8'd8,   8'd9,   8'd10,
		8'd10,  8'd11,  8'd12,  8'd13,  8'd13,  8'd14,  8'd15,  8'd16,
		8'd17,  8'd18,  8'd19,  8'd20,  8'd21,  8'd22,  8'd24,  8'd25,
		8'd26,  8'd27,  8'd29,  8'd30,  8'd32,  8'd33,  8'd35,  8'd36,
		8'd38,  8'd39,  8'd41,  8'd43,  8'd45,  8'd47,  8'd49,  8'd50,
		8'd52,  8'd55,  8'd57,  8'd59,  8'd61,  8'd63,  8'd66,  8'd68,
		8'd70,  8'd73,  8'd75,  8'd78,  8'd81,  8'd83,  8'd86,  8'd89,
		8'd92,  8'd95,  8'd98,  8'd101, 8'd104, 8'd107, 8'd110, 8'd114,
		8'd117, 8'd120, 8'd124, 8'd127, 8'd131, 8'd135, 8'd138, 8'd142,
		8'd146, 8'd150, 8'd154, 8'd158, 8'd162, 8'd167, 8'd171, 8'd175,
		8'd180, 8'd184, 8'd189, 8'd193, 8'd198, 8'd203, 8'd208, 8'd213,
		8'd218, 8'd223, 8'd228, 8'd233, 8'd239, 8'd244, 8'd249, 8'd255
	};

endpackage
`default_nettype wire

>>> hdl/midi_cc_to_gamma_pwm_duty.sv
// Top level of the MIDI control change to gamma-corrected PWM duty block.
// Items are MIDI bytes or millisecond ticks; every item yields one result with the three
// duties and the activity LED after it. One item per cycle is accepted: an item is captured
// in the input stage, and the parser update and 128-entry gamma lookup run between that
// stage and the result register. A result left waiting on m_tready holds the next item in
// the input stage, and once that stage is full s_tready drops until the result is taken.
// Configuration is to be written over the APB-style port only while no item is in flight;
// the block itself does not enforce this.
`timescale 1ns / 1ps
`default_nettype none
module midi_cc_to_gamma_pwm_duty (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [4:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [15:0] s_tdata,  // [7:0] rx_byte, [8] button_pressed
	input  wire logic        s_tuser,  // [0] kind
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [31:0]      m_tdata   // [7:0] duty_one, [15:8] duty_two,
	                                   // [23:16] duty_three, [24] activity_led
);
	import cmgp_pkg::*;

	cfg_t cfg;

	cmgp_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	cmgp_core u_core (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

endmodule
`default_nettype wire

>>> hdl/cmgp_regs.sv
// APB-style configuration registers for the MIDI CC to PWM duty block.
`timescale 1ns / 1ps
`default_nettype none
module cmgp_regs (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          psel,
	input  wire logic          penable,
	input  wire logic          pwrite,
	input  wire logic [4:0]    paddr,
	input  wire logic [31:0]   pwdata,
	output logic [31:0]        prdata,
	output logic               pready,
	output cmgp_pkg::cfg_t     cfg
);
	import cmgp_pkg::*;

	cfg_t       cfg_q;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];
	assign cfg     = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.cc_first_channel  <= CC_FIRST_RST;
			cfg_q.cc_second_channel <= CC_SECOND_RST;
			cfg_q.cc_third_channel  <= CC_THIRD_RST;
			cfg_q.midi_channel      <= MIDI_CH_RST;
			cfg_q.activity_ticks    <= ACT_TICKS_RST;
		end else if (wr_en) begin
			case (reg_idx)
				REG_CC_FIRST:  cfg_q.cc_first_channel  <= pwdata[6:0];
				REG_CC_SECOND: cfg_q.cc_second_channel <= pwdata[6:0];
				REG_CC_THIRD:  cfg_q.cc_third_channel  <= pwdata[6:0];
				REG_MIDI_CH:   cfg_q.midi_channel      <= pwdata[3:0];
				REG_ACT_TICKS: cfg_q.activity_ticks    <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (reg_idx)
			REG_CC_FIRST:  prdata = {25'd0, cfg_q.cc_first_channel};
			REG_CC_SECOND: prdata = {25'd0, cfg_q.cc_second_channel};
			REG_CC_THIRD:  prdata = {25'd0, cfg_q.cc_third_channel};
			REG_MIDI_CH:   prdata = {28'd0, cfg_q.midi_channel};
			REG_ACT_TICKS: prdata = {24'd0, cfg_q.activity_ticks};
			default:       prdata = 32'd0;
		endcase
	end

endmodule
`default_nettype wire

>>> hdl/cmgp_core.sv
// Input stage, parser state, gamma lookup and result register.
`timescale 1ns / 1ps
`default_nettype none
module cmgp_core (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire cmgp_pkg::cfg_t  cfg,
	input  wire logic            s_tvalid,
	output logic                 s_tready,
	input  wire logic [15:0]     s_tdata,
	input  wire logic            s_tuser,
	output logic                 m_tvalid,
	input  wire logic            m_tready,
	output logic [31:0]          m_tdata
);
	import cmgp_pkg::*;

	// input stage
	logic       valid_s1;
	logic       kind_s1;
	logic [7:0] byte_s1;
	logic       btn_s1;
	logic       adv;

	// parser state
	logic [7:0] status_q;
	logic       expect_q;
	logic [6:0] ctrl_q;
	logic [7:0] duty1_q, duty2_q, duty3_q;
	logic [7:0] cnt_q;
	logic       led_q;

	logic [7:0] status_d;
	logic       expect_d;
	logic [6:0] ctrl_d;
	logic [7:0] duty1_d, duty2_d, duty3_d;
	logic [7:0] cnt_d;
	logic       led_d;
	logic [7:0] level;
	logic       cc_match;

	// result register
	logic       out_vld_q;
	logic [31:0] out_data_q;

	assign adv      = valid_s1 && (!out_vld_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_vld_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tvalid && s_tready) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			kind_s1 <= s_tuser;
			byte_s1 <= s_tdata[7:0];
			btn_s1  <= s_tdata[8];
		end
	end

	assign level    = GAMMA_ROM[byte_s1[GAMMA_IDX_W-1:0]];
	assign cc_match = status_q == (CONTROL_CHANGE | {4'd0, cfg.midi_channel});

	always_comb begin
		status_d = status_q;
		expect_d = expect_q;
		ctrl_d   = ctrl_q;
		duty1_d  = duty1_q;
		duty2_d  = duty2_q;
		duty3_d  = duty3_q;
		cnt_d    = cnt_q;
		led_d    = led_q;
		if (kind_s1 == KIND_BYTE) begin
			if (byte_s1[7]) begin
				status_d = byte_s1;
				expect_d = 1'b0;
			end else if (cc_match) begin
				led_d = 1'b1;
				cnt_d = cfg.activity_ticks;
				if (!expect_q) begin
					ctrl_d   = byte_s1[6:0];
					expect_d = 1'b1;
				end else begin
					if (ctrl_q == cfg.cc_first_channel) begin
						duty1_d = level;
					end else if (ctrl_q == cfg.cc_second_channel) begin
						duty2_d = level;
					end else if (ctrl_q == cfg.cc_third_channel) begin
						duty3_d = level;
					end
					expect_d = 1'b0;
				end
			end
		end else begin
			if (cnt_q != 8'd0) begin
				cnt_d = cnt_q - 8'd1;
				if (cnt_q == 8'd1) begin
					led_d = 1'b0;
				end
			end
			if (btn_s1) begin
				duty1_d = 8'd0;
				duty2_d = 8'd0;
				duty3_d = 8'd0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			status_q <= 8'd0;
			expect_q <= 1'b0;
			ctrl_q   <= 7'd0;
			duty1_q  <= 8'd0;
			duty2_q  <= 8'd0;
			duty3_q  <= 8'd0;
			cnt_q    <= 8'd0;
			led_q    <= 1'b0;
		end else if (adv) begin
			status_q <= status_d;
			expect_q <= expect_d;
			ctrl_q   <= ctrl_d;
			duty1_q  <= duty1_d;
			duty2_q  <= duty2_d;
			duty3_q  <= duty3_d;
			cnt_q    <= cnt_d;
			led_q    <= led_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (adv) begin
			out_vld_q <= 1'b1;
		end else if (m_tready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {7'd0, led_d, duty3_d, duty2_d, duty1_d};
		end
	end

`ifndef ASSERT_OFF
	a_ready_when_free: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_vld_q && !m_tready) |-> s_tready)
		else $error("input stalled while result side free");

	a_adv_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		adv |=> out_vld_q)
		else $error("processed item produced no result");

	a_led_off_cnt_zero: assert property (@(posedge clk) disable iff (!arst_n)
		!led_q |-> (cnt_q == 8'd0))
		else $error("LED off with countdown running");

	a_status_clears_expect: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (kind_s1 == KIND_BYTE) && byte_s1[7]) |=> !expect_q)
		else $error("status byte did not reset parser");
`endif

endmodule
`default_nettype wire
